// ----- rtl/ipc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// types and fixed constants shared by the irrigation pump controller files
// ----------------------------------------------------------------------------
package ipc_pkg;

	localparam int SOIL_W    = 10;
	localparam int PCT_W     = 7;
	localparam int CLS_W     = 2;
	localparam int TICK_W    = 16;
	localparam int DEB_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int QUO_W     = 7;
	localparam int STEP_W    = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DRY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WET     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd6;

	localparam logic [CLS_W-1:0] CLS_DRY   = 2'd0;
	localparam logic [CLS_W-1:0] CLS_MOIST = 2'd1;
	localparam logic [CLS_W-1:0] CLS_WET   = 2'd2;

	localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
	localparam logic [PCT_W-1:0] PCT_WET_LEVEL = 7'd70;
	localparam logic [PCT_W-1:0] PCT_MOIST_LEVEL = 7'd40;

	localparam logic [DEB_W-1:0] RUN_MAX = 4'd15;

	typedef struct packed {
		logic [SOIL_W-1:0] dry;
		logic [SOIL_W-1:0] wet;
		logic [PCT_W-1:0]  start;
		logic [PCT_W-1:0]  hyst;
		logic [TICK_W-1:0] min_on;
		logic [TICK_W-1:0] min_off;
		logic [DEB_W-1:0]  debounce;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic linear;
	} ctrl_sts_t;

endpackage

// ----- rtl/ipc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_ifs
// valid/ready channels for input items, result items and register writes
// ----------------------------------------------------------------------------
interface ipc_item_in_if import ipc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              water_raw;
	logic [SOIL_W-1:0] soil_sample;

	modport source (output valid, output water_raw, output soil_sample, input ready);
	modport sink (input valid, input water_raw, input soil_sample, output ready);
endinterface

interface ipc_item_out_if import ipc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pump_on;
	logic [PCT_W-1:0] soil_percent;
	logic [CLS_W-1:0] soil_class;
	logic             water_present;

	modport source (output valid, output pump_on, output soil_percent, output soil_class,
		output water_present, input ready);
	modport sink (input valid, input pump_on, input soil_percent, input soil_class,
		input water_present, output ready);
endinterface

interface ipc_cfg_if import ipc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ipc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_cfg_regs
// configuration register file, written one register per accepted write
// ----------------------------------------------------------------------------
module ipc_cfg_regs import ipc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ipc_cfg_if.sink cfg,
	output cfg_t   cfg_val
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_val   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dry      <= 10'd800;
			cfg_q.wet      <= 10'd200;
			cfg_q.start    <= 7'd30;
			cfg_q.hyst     <= 7'd10;
			cfg_q.min_on   <= 16'd10;
			cfg_q.min_off  <= 16'd60;
			cfg_q.debounce <= 4'd3;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DRY:      cfg_q.dry      <= cfg.data[SOIL_W-1:0];
				CFG_WET:      cfg_q.wet      <= cfg.data[SOIL_W-1:0];
				CFG_START:    cfg_q.start    <= cfg.data[PCT_W-1:0];
				CFG_HYST:     cfg_q.hyst     <= cfg.data[PCT_W-1:0];
				CFG_MIN_ON:   cfg_q.min_on   <= cfg.data[TICK_W-1:0];
				CFG_MIN_OFF:  cfg_q.min_off  <= cfg.data[TICK_W-1:0];
				CFG_DEBOUNCE: cfg_q.debounce <= cfg.data[DEB_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/ipc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_datapath
// debounce, percent scaling with a serial divider, pump timers, result regs
// ----------------------------------------------------------------------------
module ipc_datapath import ipc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg_val,
	input  ctrl_cmd_t         cmd,
	output ctrl_sts_t         sts,
	input  logic              water_raw,
	input  logic [SOIL_W-1:0] soil_sample,
	output logic              pump_on,
	output logic [PCT_W-1:0]  soil_percent,
	output logic [CLS_W-1:0]  soil_class,
	output logic              water_present
);

	localparam int ADC_W = (ADC_BITS < SOIL_W) ? ADC_BITS : SOIL_W;
	localparam int NUM_W = ADC_W + PCT_W;

	logic [ADC_W-1:0] dry, wet, span, sample_in, diff;
	logic [ADC_W-1:0] sample_q;
	logic             high_q, low_q;
	logic [NUM_W-1:0] rem_q, trial;
	logic [QUO_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;

	logic             last_bit_q, water_q;
	logic [DEB_W-1:0] run_q;
	logic [DEB_W:0]   run_inc;
	logic [DEB_W-1:0] run_sat;

	logic              pump_q;
	logic [TICK_W-1:0] on_q, off_q;
	logic              pump_n;
	logic [TICK_W-1:0] on_n, off_n;
	logic [PCT_W-1:0]  pct_n;
	logic [CLS_W-1:0]  cls_n;
	logic [PCT_W:0]    stop_level;

	logic              res_pump_q, res_water_q;
	logic [PCT_W-1:0]  res_pct_q;
	logic [CLS_W-1:0]  res_cls_q;

	assign dry       = cfg_val.dry[ADC_W-1:0];
	assign wet       = cfg_val.wet[ADC_W-1:0];
	assign span      = dry - wet;
	assign sample_in = soil_sample[ADC_W-1:0];
	assign diff      = sample_q - wet;
	assign trial     = NUM_W'(span) << step_q;
	assign sts.linear = !high_q && !low_q;

	assign run_inc = {1'b0, run_q} + 1'b1;
	assign run_sat = run_inc[DEB_W] ? RUN_MAX : run_inc[DEB_W-1:0];

	// percent and class of the current sample
	always_comb begin
		if (high_q) begin
			pct_n = '0;
			cls_n = CLS_DRY;
		end else if (low_q) begin
			pct_n = PCT_FULL;
			cls_n = CLS_WET;
		end else begin
			pct_n = PCT_FULL - quo_q;
			if (pct_n >= PCT_WET_LEVEL) begin
				cls_n = CLS_WET;
			end else if (pct_n >= PCT_MOIST_LEVEL) begin
				cls_n = CLS_MOIST;
			end else begin
				cls_n = CLS_DRY;
			end
		end
	end

	// pump state update
	always_comb begin
		stop_level = {1'b0, cfg_val.start} + {1'b0, cfg_val.hyst};
		pump_n = pump_q;
		on_n   = on_q;
		off_n  = off_q;
		if (!water_q) begin
			pump_n = 1'b0;
			on_n   = '0;
			off_n  = '0;
		end else if (!pump_q) begin
			if (off_q != '0) begin
				off_n = off_q - 1'b1;
			end else if (pct_n < cfg_val.start) begin
				pump_n = 1'b1;
				on_n   = cfg_val.min_on;
			end
		end else begin
			if (on_q != '0) begin
				on_n = on_q - 1'b1;
			end else if ({1'b0, pct_n} >= stop_level) begin
				pump_n = 1'b0;
				off_n  = cfg_val.min_off;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_bit_q <= 1'b0;
			run_q      <= '0;
			water_q    <= 1'b0;
			pump_q     <= 1'b0;
			on_q       <= '0;
			off_q      <= '0;
		end else begin
			if (cmd.load) begin
				if (water_raw == last_bit_q) begin
					if (run_sat >= cfg_val.debounce) begin
						run_q   <= cfg_val.debounce;
						water_q <= water_raw;
					end else begin
						run_q <= run_sat;
					end
				end else begin
					run_q <= '0;
				end
				last_bit_q <= water_raw;
			end
			if (cmd.finish) begin
				pump_q <= pump_n;
				on_q   <= on_n;
				off_q  <= off_n;
			end
		end
	end

	// sample capture, multiply by 100, restoring divide msb first
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_in;
			high_q   <= (sample_in >= dry);
			low_q    <= (sample_in <= wet);
		end
		if (cmd.mul) begin
			rem_q  <= NUM_W'(diff) * NUM_W'(PCT_FULL);
			quo_q  <= '0;
			step_q <= STEP_W'(QUO_W - 1);
		end
		if (cmd.div_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			step_q <= step_q - 1'b1;
		end
		if (cmd.finish) begin
			res_pump_q  <= pump_n;
			res_pct_q   <= pct_n;
			res_cls_q   <= cls_n;
			res_water_q <= water_q;
		end
	end

	assign pump_on       = res_pump_q;
	assign soil_percent  = res_pct_q;
	assign soil_class    = res_cls_q;
	assign water_present = res_water_q;

endmodule

// ----- rtl/ipc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_ctrl
// sequencer for one item: capture, multiply, divide steps (only for a sample between wet and dry), finish
// ----------------------------------------------------------------------------
module ipc_ctrl import ipc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q, state_n;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n      = state_q;
		cmd.load     = 1'b0;
		cmd.mul      = 1'b0;
		cmd.div_step = 1'b0;
		cmd.finish   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = sts.linear ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.mul) begin
				cnt_q <= STEP_W'(QUO_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/irrigation_pump_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrigation_pump_controller_core
// debounced water gate, soil percent and class, hysteresis pump control
// sequence: accept and capture, multiply, then the serial divider steps for a
// sample between the wet and dry readings (skipped otherwise), then finish
// items are taken one at a time: no new item until the previous one finishes,
// and finish is held back while the previous result waits on ready
// reset: control, debounce and pump state and result valid clear, registers take their defaults
// ----------------------------------------------------------------------------
module irrigation_pump_controller_core import ipc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	ipc_item_in_if.sink   items,
	ipc_item_out_if.source results,
	ipc_cfg_if.sink       cfg
);

	cfg_t      cfg_val;
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	ipc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_val (cfg_val)
	);

	ipc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ipc_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_val       (cfg_val),
		.cmd           (cmd),
		.sts           (sts),
		.water_raw     (items.water_raw),
		.soil_sample   (items.soil_sample),
		.pump_on       (results.pump_on),
		.soil_percent  (results.soil_percent),
		.soil_class    (results.soil_class),
		.water_present (results.water_present)
	);

endmodule
